// ===== sv/ksl_pkg.sv =====
// ----------------------------------------------------------------------------
// ksl_pkg
// Types and constants shared by the keyed sequential list table: capacity,
// field widths, request and status codes, beat structs and sequencer states.
// ----------------------------------------------------------------------------
package ksl_pkg;

  // Table geometry
  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned IDX_W        = $clog2(CAPACITY);
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);

  // Fixed field widths of the beats
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned IN_PAY_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_PAY_W  = 32;
  localparam int unsigned OUT_CNT_W  = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  // Input beat
  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    entry_key;
    logic [IN_PAY_W-1:0] entry_payload;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_PAY_W-1:0] found_payload;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
  } out_beat_t;

endpackage

// ===== sv/keyed_sequential_list_table.sv =====
// ----------------------------------------------------------------------------
// keyed_sequential_list_table
// Fixed-capacity list of keyed entries kept packed in insertion order, with
// insert at the end, remove by key with shift-down, and lookup by key.
// ----------------------------------------------------------------------------
// One request is handled at a time, and in_ready_o is low until its result
// beat has been taken. Keys and payloads live in a single-port-write memory
// with one registered read port, and one key comparator walks the entries one
// per cycle. An insert, an unused code, or a remove or lookup on an empty list
// shows its result in the cycle right after it is accepted. A lookup reads the
// entries in order and compares each key once its registered read returns;
// it ends on a hit or after the last entry. A remove of an absent key scans
// all entries. A remove that hits at position p then moves the (count - p - 1)
// later entries down one place through the same read port, writing each one
// place lower after its read; each result then waits in the output register
// until accepted.
// ----------------------------------------------------------------------------
module keyed_sequential_list_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ksl_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ksl_pkg::out_beat_t  out_data_o
);
  import ksl_pkg::*;

  // Entry storage
  logic [KEY_W-1:0]        key_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

  // Sequencer state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]   sh_rd_q, sh_rd_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic               wr_vld_q, wr_vld_d;

  // Request and result registers
  req_e               op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  out_beat_t          out_q, out_d;

  // Memory port controls
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [KEY_W-1:0]        rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_W-1:0]        wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  logic                    in_fire;
  logic                    issue;
  logic                    hit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RESP);
  assign out_data_o  = out_q;
  assign hit         = cmp_vld_q && (rd_key_q == key_q);

  // Build a result beat from status, found payload and count after request
  function automatic out_beat_t make_beat(status_e st, logic [OUT_PAY_W-1:0] pay,
                                          logic [CNT_W-1:0] cnt);
    out_beat_t b;
    b.status        = st;
    b.found_payload = pay;
    b.entry_count   = OUT_CNT_W'(cnt);
    b.is_full       = (cnt == CNT_W'(CAPACITY));
    b.is_empty      = (cnt == '0);
    return b;
  endfunction

  // Next state, memory port control and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    sh_rd_d    = sh_rd_q;
    wr_idx_d   = wr_idx_q;
    wr_vld_d   = 1'b0;
    op_d       = op_q;
    key_d      = key_q;
    out_d      = out_q;
    rd_en      = 1'b0;
    rd_addr    = scan_idx_q[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = wr_idx_q;
    wr_key     = rd_key_q;
    wr_pay     = rd_pay_q;
    issue      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d       = req_e'(in_data_i.req_type);
          key_d      = in_data_i.entry_key;
          scan_idx_d = '0;
          case (in_data_i.req_type)
            REQ_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                out_d = make_beat(STAT_FULL, '0, count_q);
              end else begin
                // Append at the end of the list
                wr_en   = 1'b1;
                wr_addr = count_q[IDX_W-1:0];
                wr_key  = in_data_i.entry_key;
                wr_pay  = PAYLOAD_BITS'(in_data_i.entry_payload);
                count_d = count_q + CNT_W'(1);
                out_d   = make_beat(STAT_OK, '0, count_q + CNT_W'(1));
              end
              state_d = S_RESP;
            end
            REQ_REMOVE, REQ_LOOKUP: begin
              if (count_q == '0) begin
                out_d   = make_beat(STAT_EMPTY, '0, count_q);
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              // Unused code: no change
              out_d   = make_beat(STAT_OK, '0, count_q);
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read one entry per cycle, compare the one read last cycle
        issue      = (scan_idx_q < count_q);
        rd_en      = issue;
        rd_addr    = scan_idx_q[IDX_W-1:0];
        cmp_vld_d  = issue;
        cmp_idx_d  = scan_idx_q[IDX_W-1:0];
        if (issue) begin
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end
        if (hit) begin
          if (op_q == REQ_LOOKUP) begin
            out_d   = make_beat(STAT_OK, OUT_PAY_W'(rd_pay_q), count_q);
            state_d = S_RESP;
          end else begin
            // Start moving later entries down over the matched one
            rd_en   = 1'b0;
            sh_rd_d = CNT_W'(cmp_idx_q) + CNT_W'(1);
            state_d = S_SHIFT;
          end
        end else if (!issue) begin
          out_d   = make_beat(STAT_NOT_FOUND, '0, count_q);
          state_d = S_RESP;
        end
      end

      S_SHIFT: begin
        // Read entry j+1, write it to j on the next cycle
        issue   = (sh_rd_q < count_q);
        rd_en   = issue;
        rd_addr = sh_rd_q[IDX_W-1:0];
        if (issue) begin
          sh_rd_d  = sh_rd_q + CNT_W'(1);
          wr_idx_d = IDX_W'(sh_rd_q - CNT_W'(1));
          wr_vld_d = 1'b1;
        end
        wr_en   = wr_vld_q;
        wr_addr = wr_idx_q;
        if (!issue) begin
          count_d = count_q - CNT_W'(1);
          out_d   = make_beat(STAT_OK, '0, count_q - CNT_W'(1));
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        // Hold the result until taken
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      wr_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      wr_vld_q  <= wr_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    sh_rd_q    <= sh_rd_d;
    wr_idx_q   <= wr_idx_d;
    op_q       <= op_d;
    key_q      <= key_d;
    out_q      <= out_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_pay_q <= pay_mem[rd_addr];
    end
  end

endmodule
